// ===== rtl/mcsc_pkg.sv =====
package mcsc_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam int SAMPLE_W   = 31;
   localparam int KIND_W     = 2;
   localparam int CHAN_W     = 8;
   localparam int CTRL_W     = 7;
   localparam int AMOUNT_W   = 15;
   localparam int PAYLOAD_W  = 32;
   localparam int CC_VAL_W   = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;

   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_END   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_NOTE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CC    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BEND  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

   localparam logic [CTRL_W-1:0] CC_VOLUME     = 7'd7;
   localparam logic [CTRL_W-1:0] CC_EXPRESSION = 7'd11;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_END   = 1'b1;

   localparam logic [SAMPLE_W-1:0] WINDOW_START_RESET = '0;
   localparam logic [SAMPLE_W-1:0] WINDOW_END_RESET   = '1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] win_start;
      logic [SAMPLE_W-1:0] win_end;
   } cfg_type;

   typedef struct packed {
      logic [AMOUNT_W-1:0] bend;
      logic [CC_VAL_W-1:0] expr;
      logic [CC_VAL_W-1:0] vol;
   } chan_state_type;

   localparam int STATE_W = $bits(chan_state_type);

   typedef struct packed {
      logic           rd_en;
      logic [CH_W-1:0] rd_addr;
      logic           wr_en;
      logic [CH_W-1:0] wr_addr;
      chan_state_type wr_data;
   } ram_cmd_type;

endpackage

// ===== rtl/mcsc_ifs.sv =====
interface mcsc_req_if;
   logic                               valid;
   logic                               ready;
   logic                               operation;
   logic [mcsc_pkg::SAMPLE_W-1:0]        sample_pos;
   logic [mcsc_pkg::KIND_W-1:0]          kind;
   logic [mcsc_pkg::CHAN_W-1:0]          chan;
   logic [mcsc_pkg::CTRL_W-1:0]          ctrl_number;
   logic signed [mcsc_pkg::AMOUNT_W-1:0] amount;
   logic [mcsc_pkg::PAYLOAD_W-1:0]       payload;

   modport source (
      output valid, operation, sample_pos, kind, chan, ctrl_number, amount, payload,
      input  ready
   );
   modport sink (
      input  valid, operation, sample_pos, kind, chan, ctrl_number, amount, payload,
      output ready
   );
endinterface

interface mcsc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mcsc_pkg::SAMPLE_W-1:0]        out_sample;
   logic [mcsc_pkg::KIND_W-1:0]          out_kind;
   logic [mcsc_pkg::CHAN_W-1:0]          out_chan;
   logic [mcsc_pkg::CTRL_W-1:0]          out_ctrl;
   logic signed [mcsc_pkg::AMOUNT_W-1:0] out_amount;
   logic [mcsc_pkg::PAYLOAD_W-1:0]       out_payload;
   logic                               last;

   modport source (
      output valid, out_sample, out_kind, out_chan, out_ctrl, out_amount, out_payload, last,
      input  ready
   );
   modport sink (
      input  valid, out_sample, out_kind, out_chan, out_ctrl, out_amount, out_payload, last,
      output ready
   );
endinterface

// ===== rtl/mcsc_ram.sv =====
module mcsc_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 29
) (
   input  logic                                  clock,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mcsc_ctrl.sv =====
module mcsc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  mcsc_pkg::cfg_type           cfg,
   mcsc_req_if.sink                    req,
   mcsc_rsp_if.source                  rsp,
   output mcsc_pkg::ram_cmd_type       ram_cmd,
   input  mcsc_pkg::chan_state_type    ram_rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRACK,
      ST_FL_READ,
      ST_FL_EMIT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      AFT_EVENT,
      AFT_DROP,
      AFT_END
   } after_type;

   typedef enum logic [1:0] {
      FLD_VOL,
      FLD_EXPR,
      FLD_BEND
   } field_type;

   state_type state_ff;
   after_type after_ff;
   field_type fld_ff;

   logic [mcsc_pkg::NUM_CHANNELS-1:0] vol_seen_ff;
   logic [mcsc_pkg::NUM_CHANNELS-1:0] expr_seen_ff;
   logic [mcsc_pkg::NUM_CHANNELS-1:0] bend_seen_ff;
   logic                              flushed_ff;
   logic                              past_ff;
   logic [mcsc_pkg::CH_W-1:0]         ch_ff;

   logic [mcsc_pkg::SAMPLE_W-1:0]        item_sample_ff;
   logic [mcsc_pkg::KIND_W-1:0]          item_kind_ff;
   logic [mcsc_pkg::CHAN_W-1:0]          item_chan_ff;
   logic [mcsc_pkg::CTRL_W-1:0]          item_ctrl_ff;
   logic [mcsc_pkg::AMOUNT_W-1:0]        item_amount_ff;
   logic [mcsc_pkg::PAYLOAD_W-1:0]       item_payload_ff;
   logic [mcsc_pkg::CH_W-1:0]            item_ch_ff;

   logic                                 rsp_valid_ff;
   logic [mcsc_pkg::SAMPLE_W-1:0]        rsp_sample_ff;
   logic [mcsc_pkg::KIND_W-1:0]          rsp_kind_ff;
   logic [mcsc_pkg::CHAN_W-1:0]          rsp_chan_ff;
   logic [mcsc_pkg::CTRL_W-1:0]          rsp_ctrl_ff;
   logic signed [mcsc_pkg::AMOUNT_W-1:0] rsp_amount_ff;
   logic [mcsc_pkg::PAYLOAD_W-1:0]       rsp_payload_ff;
   logic                                 rsp_last_ff;

   logic [mcsc_pkg::CH_W-1:0]         req_ch;
   logic                              is_end;
   logic                              early;
   logic                              late;
   logic                              trk_vol;
   logic                              trk_expr;
   logic                              trk_bend;
   logic                              seen_any;
   logic                              cur_vol;
   logic                              cur_expr;
   logic                              cur_bend;
   logic                              cur_any;
   logic                              out_free;
   logic                              rsp_load;
   logic [mcsc_pkg::NUM_CHANNELS-1:0] ch_bit;
   logic [mcsc_pkg::NUM_CHANNELS-1:0] vol_left;
   logic [mcsc_pkg::NUM_CHANNELS-1:0] expr_left;
   logic [mcsc_pkg::NUM_CHANNELS-1:0] bend_left;
   logic                              pre_last;
   mcsc_pkg::chan_state_type          merged;

   assign req_ch = (req.chan < mcsc_pkg::CHAN_W'(mcsc_pkg::NUM_CHANNELS)) ?
                   req.chan[mcsc_pkg::CH_W-1:0] : '0;
   assign is_end   = (req.operation == mcsc_pkg::OP_END);
   assign early    = (req.sample_pos < cfg.win_start);
   assign late     = (req.sample_pos > cfg.win_end);
   assign trk_vol  = (req.kind == mcsc_pkg::KIND_CC) && (req.ctrl_number == mcsc_pkg::CC_VOLUME);
   assign trk_expr = (req.kind == mcsc_pkg::KIND_CC) &&
                     (req.ctrl_number == mcsc_pkg::CC_EXPRESSION);
   assign trk_bend = (req.kind == mcsc_pkg::KIND_BEND);

   assign seen_any = |{vol_seen_ff, expr_seen_ff, bend_seen_ff};
   assign cur_vol  = vol_seen_ff[ch_ff];
   assign cur_expr = expr_seen_ff[ch_ff];
   assign cur_bend = bend_seen_ff[ch_ff];
   assign cur_any  = cur_vol || cur_expr || cur_bend;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign rsp_load = out_free && ((state_ff == ST_FL_EMIT && cur_any) || state_ff == ST_EMIT);

   assign ch_bit    = mcsc_pkg::NUM_CHANNELS'(1) << ch_ff;
   assign vol_left  = vol_seen_ff & ~(cur_vol ? ch_bit : '0);
   assign expr_left = expr_seen_ff & ~((!cur_vol && cur_expr) ? ch_bit : '0);
   assign bend_left = bend_seen_ff & ~((!cur_vol && !cur_expr) ? ch_bit : '0);
   assign pre_last  = (after_ff != AFT_EVENT) && !(|{vol_left, expr_left, bend_left});

   always_comb begin
      merged = ram_rd_data;
      case (fld_ff)
         FLD_VOL:  merged.vol  = item_amount_ff[mcsc_pkg::CC_VAL_W-1:0];
         FLD_EXPR: merged.expr = item_amount_ff[mcsc_pkg::CC_VAL_W-1:0];
         FLD_BEND: merged.bend = item_amount_ff;
         default:  merged = ram_rd_data;
      endcase
   end

   assign ram_cmd.rd_en   = (req.valid && req.ready) ||
                            (state_ff == ST_FL_READ && seen_any);
   assign ram_cmd.rd_addr = (state_ff == ST_IDLE) ? req_ch : ch_ff;
   assign ram_cmd.wr_en   = (state_ff == ST_TRACK);
   assign ram_cmd.wr_addr = item_ch_ff;
   assign ram_cmd.wr_data = merged;

   assign req.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vol_seen_ff  <= '0;
         expr_seen_ff <= '0;
         bend_seen_ff <= '0;
         flushed_ff   <= 1'b0;
         past_ff      <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  item_sample_ff  <= req.sample_pos;
                  item_kind_ff    <= req.kind;
                  item_chan_ff    <= req.chan;
                  item_ctrl_ff    <= req.ctrl_number;
                  item_amount_ff  <= req.amount;
                  item_payload_ff <= req.payload;
                  item_ch_ff      <= req_ch;
                  ch_ff           <= '0;
                  if (is_end) begin
                     if (!flushed_ff) begin
                        after_ff <= AFT_END;
                        state_ff <= ST_FL_READ;
                     end else begin
                        vol_seen_ff  <= '0;
                        expr_seen_ff <= '0;
                        bend_seen_ff <= '0;
                        flushed_ff   <= 1'b0;
                        past_ff      <= 1'b0;
                     end
                  end else if (past_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (early) begin
                     if (!flushed_ff) begin
                        if (trk_vol) begin
                           vol_seen_ff[req_ch] <= 1'b1;
                           fld_ff              <= FLD_VOL;
                           state_ff            <= ST_TRACK;
                        end else if (trk_expr) begin
                           expr_seen_ff[req_ch] <= 1'b1;
                           fld_ff               <= FLD_EXPR;
                           state_ff             <= ST_TRACK;
                        end else if (trk_bend) begin
                           bend_seen_ff[req_ch] <= 1'b1;
                           fld_ff               <= FLD_BEND;
                           state_ff             <= ST_TRACK;
                        end
                     end
                  end else if (late) begin
                     if (!flushed_ff) begin
                        after_ff <= AFT_DROP;
                        state_ff <= ST_FL_READ;
                     end else begin
                        past_ff <= 1'b1;
                     end
                  end else begin
                     after_ff <= AFT_EVENT;
                     state_ff <= flushed_ff ? ST_EMIT : ST_FL_READ;
                  end
               end
            end
            ST_TRACK: begin
               state_ff <= ST_IDLE;
            end
            ST_FL_READ: begin
               if (!seen_any) begin
                  case (after_ff)
                     AFT_EVENT: begin
                        flushed_ff <= 1'b1;
                        state_ff   <= ST_EMIT;
                     end
                     AFT_DROP: begin
                        flushed_ff <= 1'b1;
                        past_ff    <= 1'b1;
                        state_ff   <= ST_IDLE;
                     end
                     AFT_END: begin
                        flushed_ff <= 1'b0;
                        past_ff    <= 1'b0;
                        state_ff   <= ST_IDLE;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end else begin
                  state_ff <= ST_FL_EMIT;
               end
            end
            ST_FL_EMIT: begin
               if (!cur_any) begin
                  ch_ff    <= ch_ff + mcsc_pkg::CH_W'(1);
                  state_ff <= ST_FL_READ;
               end else if (out_free) begin
                  rsp_sample_ff  <= '0;
                  rsp_chan_ff    <= mcsc_pkg::CHAN_W'(ch_ff);
                  rsp_payload_ff <= '0;
                  rsp_last_ff    <= pre_last;
                  vol_seen_ff    <= vol_left;
                  expr_seen_ff   <= expr_left;
                  bend_seen_ff   <= bend_left;
                  if (cur_vol) begin
                     rsp_kind_ff   <= mcsc_pkg::KIND_CC;
                     rsp_ctrl_ff   <= mcsc_pkg::CC_VOLUME;
                     rsp_amount_ff <= mcsc_pkg::AMOUNT_W'(ram_rd_data.vol);
                  end else if (cur_expr) begin
                     rsp_kind_ff   <= mcsc_pkg::KIND_CC;
                     rsp_ctrl_ff   <= mcsc_pkg::CC_EXPRESSION;
                     rsp_amount_ff <= mcsc_pkg::AMOUNT_W'(ram_rd_data.expr);
                  end else begin
                     rsp_kind_ff   <= mcsc_pkg::KIND_BEND;
                     rsp_ctrl_ff   <= '0;
                     rsp_amount_ff <= ram_rd_data.bend;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_sample_ff  <= item_sample_ff - cfg.win_start;
                  rsp_kind_ff    <= item_kind_ff;
                  rsp_chan_ff    <= item_chan_ff;
                  rsp_ctrl_ff    <= item_ctrl_ff;
                  rsp_amount_ff  <= item_amount_ff;
                  rsp_payload_ff <= item_payload_ff;
                  rsp_last_ff    <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_sample  = rsp_sample_ff;
   assign rsp.out_kind    = rsp_kind_ff;
   assign rsp.out_chan    = rsp_chan_ff;
   assign rsp.out_ctrl    = rsp_ctrl_ff;
   assign rsp.out_amount  = rsp_amount_ff;
   assign rsp.out_payload = rsp_payload_ff;
   assign rsp.last        = rsp_last_ff;

   a_flush_before_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FL_READ || state_ff == ST_FL_EMIT) |-> !flushed_ff)
      else $error("flush running with prefix already flushed");

   a_past_after_flush: assert property (@(posedge clock) disable iff (reset)
      past_ff |-> flushed_ff)
      else $error("past window set without prefix flush");

   a_seen_before_flush: assert property (@(posedge clock) disable iff (reset)
      (|{vol_seen_ff, expr_seen_ff, bend_seen_ff}) |-> !flushed_ff)
      else $error("tracked state left after prefix flush");

endmodule

// ===== rtl/midi_window_state_chase.sv =====
// Channel  Dir  Handshake        Content
// req_bus  in   valid/ready      operation, sample_pos, kind, chan, ctrl_number, amount, payload
// rsp_bus  out  valid/ready      out_sample, out_kind, out_chan, out_ctrl, out_amount,
//                                out_payload, last
// csr_*    in   csr_we           csr_index selects window_start or window_end, csr_wdata
//
// One item at a time; req_bus.ready is high only while the controller is idle.
// Tracked items pass through a RAM write state, in-window items through an emit state that
// waits out output stalls; other items are dropped from idle unless they start a prefix flush.
// A prefix flush walks the channel state RAM up to the last channel holding state, emits each
// tracked item as the output register frees, then goes on to the in-window item, drop or end.
// Synchronous reset clears control state and resets the window registers; no clearing pass.
// A stalled output holds its item; the flush waits on the output register.
module midi_window_state_chase (
   input  logic                                 clock,
   input  logic                                 reset,
   mcsc_req_if.sink                             req_bus,
   mcsc_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [mcsc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mcsc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [mcsc_pkg::SAMPLE_W-1:0] win_start_ff;
   logic [mcsc_pkg::SAMPLE_W-1:0] win_end_ff;
   mcsc_pkg::cfg_type             cfg;
   mcsc_pkg::ram_cmd_type         ram_cmd;
   mcsc_pkg::chan_state_type      ram_rd_data;
   logic [mcsc_pkg::STATE_W-1:0]  ram_rd_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= mcsc_pkg::WINDOW_START_RESET;
         win_end_ff   <= mcsc_pkg::WINDOW_END_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mcsc_pkg::CSR_WINDOW_START: win_start_ff <= csr_wdata;
            mcsc_pkg::CSR_WINDOW_END:   win_end_ff   <= csr_wdata;
            default:                    win_start_ff <= win_start_ff;
         endcase
      end
   end

   assign cfg.win_start = win_start_ff;
   assign cfg.win_end   = win_end_ff;
   assign ram_rd_data   = mcsc_pkg::chan_state_type'(ram_rd_bits);

   mcsc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data)
   );

   mcsc_ram #(
      .DEPTH (mcsc_pkg::NUM_CHANNELS),
      .WIDTH (mcsc_pkg::STATE_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rd_bits),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data)
   );

endmodule

// ===== test/tb_midi_window_state_chase.sv =====
`timescale 1ns / 100ps

module tb_midi_window_state_chase;

   localparam int RANDOM_ITEMS      = 225;
   localparam int SETTLE_CYCLES     = 100;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int DRAIN_LIMIT       = 20000;
   localparam logic [mcsc_pkg::SAMPLE_W-1:0] SAMPLE_MAX = '1;

   typedef struct packed {
      logic                           op;
      logic [mcsc_pkg::SAMPLE_W-1:0]  sample;
      logic [mcsc_pkg::KIND_W-1:0]    kind;
      logic [mcsc_pkg::CHAN_W-1:0]    chan;
      logic [mcsc_pkg::CTRL_W-1:0]    ctrl;
      logic [mcsc_pkg::AMOUNT_W-1:0]  amount;
      logic [mcsc_pkg::PAYLOAD_W-1:0] payload;
   } midi_item_type;

   typedef struct packed {
      logic [mcsc_pkg::SAMPLE_W-1:0]  sample;
      logic [mcsc_pkg::KIND_W-1:0]    kind;
      logic [mcsc_pkg::CHAN_W-1:0]    chan;
      logic [mcsc_pkg::CTRL_W-1:0]    ctrl;
      logic [mcsc_pkg::AMOUNT_W-1:0]  amount;
      logic [mcsc_pkg::PAYLOAD_W-1:0] payload;
      logic                           last;
   } chase_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                            csr_we;
   logic [mcsc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mcsc_pkg::CSR_DATA_W-1:0] csr_wdata;

   mcsc_req_if req_bus ();
   mcsc_rsp_if rsp_bus ();

   midi_window_state_chase uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // chased controller state and window, as the block should hold them
   logic                          vol_known  [mcsc_pkg::NUM_CHANNELS];
   logic [mcsc_pkg::CC_VAL_W-1:0] vol_level  [mcsc_pkg::NUM_CHANNELS];
   logic                          expr_known [mcsc_pkg::NUM_CHANNELS];
   logic [mcsc_pkg::CC_VAL_W-1:0] expr_level [mcsc_pkg::NUM_CHANNELS];
   logic                          bend_known [mcsc_pkg::NUM_CHANNELS];
   logic [mcsc_pkg::AMOUNT_W-1:0] bend_level [mcsc_pkg::NUM_CHANNELS];
   logic                          prefix_sent;
   logic                          beyond_window;
   logic [mcsc_pkg::SAMPLE_W-1:0] win_start;
   logic [mcsc_pkg::SAMPLE_W-1:0] win_end;

   chase_result_type expected_q[$];

   int  mismatch_count  = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   int  window_settings = 0;
   bit  gaps_on;
   bit  stalls_on;
   bit  hold_output     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_chase_state();
      for (int ch = 0; ch < mcsc_pkg::NUM_CHANNELS; ch++) begin
         vol_known[ch]  = 1'b0;
         vol_level[ch]  = '0;
         expr_known[ch] = 1'b0;
         expr_level[ch] = '0;
         bend_known[ch] = 1'b0;
         bend_level[ch] = '0;
      end
      prefix_sent   = 1'b0;
      beyond_window = 1'b0;
   endfunction

   function automatic void push_result(input logic [mcsc_pkg::SAMPLE_W-1:0] sample,
                                       input logic [mcsc_pkg::KIND_W-1:0] kind,
                                       input logic [mcsc_pkg::CHAN_W-1:0] chan,
                                       input logic [mcsc_pkg::CTRL_W-1:0] ctrl,
                                       input logic [mcsc_pkg::AMOUNT_W-1:0] amount,
                                       input logic [mcsc_pkg::PAYLOAD_W-1:0] payload);
      chase_result_type r;
      r.sample  = sample;
      r.kind    = kind;
      r.chan    = chan;
      r.ctrl    = ctrl;
      r.amount  = amount;
      r.payload = payload;
      r.last    = 1'b0;
      expected_q = {expected_q, r};
   endfunction

   function automatic int flush_chased_state();
      int n;
      n = 0;
      for (int ch = 0; ch < mcsc_pkg::NUM_CHANNELS; ch++) begin
         if (vol_known[ch]) begin
            push_result('0, mcsc_pkg::KIND_CC, mcsc_pkg::CHAN_W'(ch), mcsc_pkg::CC_VOLUME,
                        mcsc_pkg::AMOUNT_W'(vol_level[ch]), '0);
            n++;
         end
         if (expr_known[ch]) begin
            push_result('0, mcsc_pkg::KIND_CC, mcsc_pkg::CHAN_W'(ch), mcsc_pkg::CC_EXPRESSION,
                        mcsc_pkg::AMOUNT_W'(expr_level[ch]), '0);
            n++;
         end
         if (bend_known[ch]) begin
            push_result('0, mcsc_pkg::KIND_BEND, mcsc_pkg::CHAN_W'(ch), '0, bend_level[ch],
                        '0);
            n++;
         end
      end
      prefix_sent = 1'b1;
      return n;
   endfunction

   function automatic void predict_item(input midi_item_type it);
      int               n;
      int               ch;
      chase_result_type r;
      n = 0;
      if (it.op == mcsc_pkg::OP_END) begin
         if (!prefix_sent)
            n = flush_chased_state();
         clear_chase_state();
      end else if (beyond_window) begin
         n = 0;
      end else if (it.sample < win_start) begin
         if (!prefix_sent) begin
            ch = (it.chan < mcsc_pkg::NUM_CHANNELS) ? int'(it.chan) : 0;
            if (it.kind == mcsc_pkg::KIND_CC && it.ctrl == mcsc_pkg::CC_VOLUME) begin
               vol_known[ch] = 1'b1;
               vol_level[ch] = it.amount[mcsc_pkg::CC_VAL_W-1:0];
            end else if (it.kind == mcsc_pkg::KIND_CC && it.ctrl == mcsc_pkg::CC_EXPRESSION) begin
               expr_known[ch] = 1'b1;
               expr_level[ch] = it.amount[mcsc_pkg::CC_VAL_W-1:0];
            end else if (it.kind == mcsc_pkg::KIND_BEND) begin
               bend_known[ch] = 1'b1;
               bend_level[ch] = it.amount;
            end
         end
      end else if (it.sample > win_end) begin
         if (!prefix_sent)
            n = flush_chased_state();
         beyond_window = 1'b1;
      end else begin
         if (!prefix_sent)
            n = flush_chased_state();
         push_result(it.sample - win_start, it.kind, it.chan, it.ctrl, it.amount, it.payload);
         n++;
      end
      if (n > 0) begin
         r = expected_q[expected_q.size()-1];
         r.last = 1'b1;
         expected_q[expected_q.size()-1] = r;
      end
   endfunction

   function automatic logic [mcsc_pkg::CHAN_W-1:0] random_chan();
      if ($urandom_range(0, 4) == 0)
         return mcsc_pkg::CHAN_W'($urandom_range(255, mcsc_pkg::NUM_CHANNELS));
      return mcsc_pkg::CHAN_W'($urandom_range(mcsc_pkg::NUM_CHANNELS - 1, 0));
   endfunction

   task automatic send_item(input midi_item_type it);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(10, 1)) @(negedge clock);
      end
      req_bus.operation   = it.op;
      req_bus.sample_pos  = it.sample;
      req_bus.kind        = it.kind;
      req_bus.chan        = it.chan;
      req_bus.ctrl_number = it.ctrl;
      req_bus.amount      = it.amount;
      req_bus.payload     = it.payload;
      req_bus.valid       = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_item(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_event(input logic [mcsc_pkg::SAMPLE_W-1:0] sample,
                             input logic [mcsc_pkg::KIND_W-1:0] kind,
                             input logic [mcsc_pkg::CHAN_W-1:0] chan,
                             input logic [mcsc_pkg::CTRL_W-1:0] ctrl,
                             input logic [mcsc_pkg::AMOUNT_W-1:0] amount,
                             input logic [mcsc_pkg::PAYLOAD_W-1:0] payload);
      midi_item_type it;
      it.op      = mcsc_pkg::OP_EVENT;
      it.sample  = sample;
      it.kind    = kind;
      it.chan    = chan;
      it.ctrl    = ctrl;
      it.amount  = amount;
      it.payload = payload;
      send_item(it);
   endtask

   task automatic send_end_marker();
      midi_item_type it;
      it.op      = mcsc_pkg::OP_END;
      it.sample  = mcsc_pkg::SAMPLE_W'($urandom);
      it.kind    = mcsc_pkg::KIND_W'($urandom);
      it.chan    = mcsc_pkg::CHAN_W'($urandom);
      it.ctrl    = mcsc_pkg::CTRL_W'($urandom);
      it.amount  = mcsc_pkg::AMOUNT_W'($urandom);
      it.payload = $urandom;
      send_item(it);
   endtask

   task automatic send_random_event(input logic [mcsc_pkg::SAMPLE_W-1:0] sample);
      logic [mcsc_pkg::KIND_W-1:0] kind;
      logic [mcsc_pkg::CTRL_W-1:0] ctrl;
      case ($urandom_range(0, 7))
         0, 1: begin
            kind = mcsc_pkg::KIND_CC;
            ctrl = mcsc_pkg::CC_VOLUME;
         end
         2, 3: begin
            kind = mcsc_pkg::KIND_CC;
            ctrl = mcsc_pkg::CC_EXPRESSION;
         end
         4, 5: begin
            kind = mcsc_pkg::KIND_BEND;
            ctrl = mcsc_pkg::CTRL_W'($urandom);
         end
         6: begin
            kind = $urandom_range(0, 1) ? mcsc_pkg::KIND_NOTE : mcsc_pkg::KIND_OTHER;
            ctrl = mcsc_pkg::CTRL_W'($urandom);
         end
         default: begin
            kind = mcsc_pkg::KIND_CC;
            ctrl = mcsc_pkg::CTRL_W'($urandom);
         end
      endcase
      send_event(sample, kind, random_chan(), ctrl, mcsc_pkg::AMOUNT_W'($urandom), $urandom);
   endtask

   // wait until the block has nothing left to emit
   task automatic settle_block();
      req_bus.valid = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_window(input logic [mcsc_pkg::SAMPLE_W-1:0] first,
                             input logic [mcsc_pkg::SAMPLE_W-1:0] final_pos);
      settle_block();
      csr_we    = 1'b1;
      csr_index = mcsc_pkg::CSR_WINDOW_START;
      csr_wdata = first;
      @(negedge clock);
      csr_index = mcsc_pkg::CSR_WINDOW_END;
      csr_wdata = final_pos;
      @(negedge clock);
      csr_we    = 1'b0;
      win_start = first;
      win_end   = final_pos;
      window_settings++;
   endtask

   task automatic test_reset_pass_through();
      send_event('0, mcsc_pkg::KIND_NOTE, 8'd0, 7'd0, 15'h6000, 32'h0000_0000);
      send_event(SAMPLE_MAX, mcsc_pkg::KIND_CC, 8'hFF, 7'h7F, 15'h3FFF, 32'hFFFF_FFFF);
      send_event(31'd12345, mcsc_pkg::KIND_BEND, 8'd9, 7'd0, 15'h7FFF, 32'hA5A5_5A5A);
      send_event(31'd777, mcsc_pkg::KIND_OTHER, 8'd16, mcsc_pkg::CC_EXPRESSION, 15'h0000,
                 32'h1234_5678);
      send_end_marker();
   endtask

   task automatic test_chase_into_window();
      set_window(31'd1000, 31'd2000);
      send_event(31'd10, mcsc_pkg::KIND_CC, 8'd3, mcsc_pkg::CC_VOLUME, 15'h12C5, $urandom);
      send_event(31'd20, mcsc_pkg::KIND_CC, 8'd3, mcsc_pkg::CC_EXPRESSION, 15'h7F80, $urandom);
      send_event(31'd30, mcsc_pkg::KIND_BEND, 8'd3, 7'd0, 15'h6000, $urandom);
      send_event(31'd40, mcsc_pkg::KIND_CC, 8'd200, mcsc_pkg::CC_VOLUME, 15'h0055, $urandom);
      send_event(31'd50, mcsc_pkg::KIND_CC, 8'd16, mcsc_pkg::CC_EXPRESSION, 15'h3FFF,
                 $urandom);
      send_event(31'd60, mcsc_pkg::KIND_NOTE, 8'd5, mcsc_pkg::CC_VOLUME, 15'h0011, $urandom);
      send_event(31'd70, mcsc_pkg::KIND_CC, 8'd5, 7'd10, 15'h0022, $urandom);
      send_event(31'd1500, mcsc_pkg::KIND_NOTE, 8'd5, 7'd60, 15'h0064, 32'hDEAD_BEEF);
      send_event(31'd900, mcsc_pkg::KIND_CC, 8'd6, mcsc_pkg::CC_VOLUME, 15'h0033, $urandom);
      send_event(31'd2000, mcsc_pkg::KIND_CC, 8'd6, mcsc_pkg::CC_VOLUME, 15'h0044,
                 32'h0000_0001);
      send_event(31'd2001, mcsc_pkg::KIND_NOTE, 8'd1, 7'd1, 15'h0001, $urandom);
      send_event(31'd1200, mcsc_pkg::KIND_NOTE, 8'd1, 7'd1, 15'h0001, $urandom);
      send_end_marker();
   endtask

   task automatic test_flush_on_past_event();
      send_event(31'd999, mcsc_pkg::KIND_BEND, 8'd15, 7'd0, 15'h1FFF, $urandom);
      send_event(31'd500, mcsc_pkg::KIND_CC, 8'd9, mcsc_pkg::CC_EXPRESSION, 15'h0F0F, $urandom);
      send_event(31'd5000, mcsc_pkg::KIND_NOTE, 8'd2, 7'd64, 15'h0100, $urandom);
      send_end_marker();
   endtask

   task automatic test_flush_on_end_marker();
      send_event(31'd5, mcsc_pkg::KIND_BEND, 8'hFF, 7'd0, 15'h4000, $urandom);
      send_end_marker();
      send_end_marker();
   endtask

   task automatic test_inverted_window();
      set_window(31'd500, 31'd100);
      send_event(31'd50, mcsc_pkg::KIND_CC, 8'd2, mcsc_pkg::CC_VOLUME, 15'h007F, $urandom);
      send_event(31'd300, mcsc_pkg::KIND_NOTE, 8'd2, 7'd1, 15'h0001, $urandom);
      send_end_marker();
   endtask

   task automatic test_window_extremes();
      set_window(SAMPLE_MAX, SAMPLE_MAX);
      send_event(SAMPLE_MAX - 31'd1, mcsc_pkg::KIND_CC, 8'd1, mcsc_pkg::CC_VOLUME, 15'h0002,
                 $urandom);
      send_event(SAMPLE_MAX, mcsc_pkg::KIND_NOTE, 8'd1, 7'd3, 15'h0004, $urandom);
      send_end_marker();
      set_window('0, '0);
      send_event('0, mcsc_pkg::KIND_OTHER, 8'd4, 7'd5, 15'h0006, $urandom);
      send_event(31'd1, mcsc_pkg::KIND_NOTE, 8'd4, 7'd5, 15'h0006, $urandom);
      send_end_marker();
   endtask

   // every channel holds all three states, then the output stalls for a long stretch
   task automatic test_stalled_flush();
      logic [mcsc_pkg::CHAN_W-1:0] chan;
      set_window(31'd100000, 31'd200000);
      for (int ch = 0; ch < mcsc_pkg::NUM_CHANNELS; ch++) begin
         chan = (ch == 0) ? mcsc_pkg::CHAN_W'($urandom_range(255, mcsc_pkg::NUM_CHANNELS)) :
                            mcsc_pkg::CHAN_W'(ch);
         send_event(mcsc_pkg::SAMPLE_W'(ch * 3000 + 10), mcsc_pkg::KIND_CC, chan,
                    mcsc_pkg::CC_VOLUME, mcsc_pkg::AMOUNT_W'($urandom), $urandom);
         send_event(mcsc_pkg::SAMPLE_W'(ch * 3000 + 20), mcsc_pkg::KIND_CC, chan,
                    mcsc_pkg::CC_EXPRESSION, mcsc_pkg::AMOUNT_W'($urandom), $urandom);
         send_event(mcsc_pkg::SAMPLE_W'(ch * 3000 + 30), mcsc_pkg::KIND_BEND, chan,
                    mcsc_pkg::CTRL_W'($urandom), mcsc_pkg::AMOUNT_W'($urandom), $urandom);
      end
      hold_output = 1'b1;
      send_event(31'd150000, mcsc_pkg::KIND_NOTE, 8'd3, 7'd60, mcsc_pkg::AMOUNT_W'($urandom),
                 $urandom);
      send_event(31'd150100, mcsc_pkg::KIND_CC, 8'd7, mcsc_pkg::CC_VOLUME,
                 mcsc_pkg::AMOUNT_W'($urandom), $urandom);
      send_event(31'd160000, mcsc_pkg::KIND_BEND, 8'd12, 7'd0, mcsc_pkg::AMOUNT_W'($urandom),
                 $urandom);
      send_end_marker();
   endtask

   task automatic test_random_windows();
      logic [mcsc_pkg::SAMPLE_W-1:0] first;
      logic [mcsc_pkg::SAMPLE_W-1:0] final_pos;
      logic [mcsc_pkg::SAMPLE_W-1:0] pos;
      longint                        lim;
      midi_item_type                 noise;
      int                            stop_at;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         if (items_sent >= stop_at - RANDOM_ITEMS / 4) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         case ($urandom_range(0, 9))
            0: begin
               first     = mcsc_pkg::SAMPLE_W'($urandom);
               final_pos = mcsc_pkg::SAMPLE_W'($urandom);
            end
            1: begin
               first     = '0;
               final_pos = mcsc_pkg::SAMPLE_W'($urandom_range(3000, 0));
            end
            2: begin
               first     = mcsc_pkg::SAMPLE_W'($urandom_range(3000, 0));
               final_pos = SAMPLE_MAX;
            end
            3: begin
               first     = mcsc_pkg::SAMPLE_W'($urandom_range(3000, 100));
               final_pos = mcsc_pkg::SAMPLE_W'(first - $urandom_range(99, 1));
            end
            default: begin
               first     = mcsc_pkg::SAMPLE_W'($urandom_range(3000, 0));
               final_pos = mcsc_pkg::SAMPLE_W'(first + $urandom_range(3000, 0));
            end
         endcase
         set_window(first, final_pos);
         if (first > 0) begin
            pos = (first > 5000) ? first - 31'd5000 : '0;
            repeat ($urandom_range(14, 0)) begin
               pos = mcsc_pkg::SAMPLE_W'($urandom_range(first - 32'd1, pos));
               send_random_event(pos);
            end
         end
         if (first <= final_pos) begin
            pos = first;
            repeat ($urandom_range(6, 0)) begin
               lim = longint'(pos) + 400;
               if (lim > final_pos)
                  lim = final_pos;
               pos = mcsc_pkg::SAMPLE_W'($urandom_range(lim, pos));
               send_random_event(pos);
            end
            if (first > 0 && $urandom_range(0, 2) == 0)
               send_random_event(mcsc_pkg::SAMPLE_W'($urandom_range(first - 32'd1, 0)));
         end
         if (final_pos != SAMPLE_MAX) begin
            repeat ($urandom_range(2, 0)) begin
               lim = longint'(final_pos) + 1000;
               if (lim > SAMPLE_MAX)
                  lim = SAMPLE_MAX;
               send_random_event(mcsc_pkg::SAMPLE_W'($urandom_range(lim, final_pos + 32'd1)));
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            noise.op      = $urandom_range(0, 1) ? mcsc_pkg::OP_END : mcsc_pkg::OP_EVENT;
            noise.sample  = mcsc_pkg::SAMPLE_W'($urandom);
            noise.kind    = mcsc_pkg::KIND_W'($urandom);
            noise.chan    = mcsc_pkg::CHAN_W'($urandom);
            noise.ctrl    = mcsc_pkg::CTRL_W'($urandom);
            noise.amount  = mcsc_pkg::AMOUNT_W'($urandom);
            noise.payload = $urandom;
            send_item(noise);
         end
         if ($urandom_range(0, 7) != 0)
            send_end_marker();
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : result_checker
      chase_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual sample %0h chan %0h",
                     $time, rsp_bus.out_sample, rsp_bus.out_chan);
            mismatch_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("out_sample", 32'(want.sample), 32'(rsp_bus.out_sample));
            check_field("out_kind", 32'(want.kind), 32'(rsp_bus.out_kind));
            check_field("out_chan", 32'(want.chan), 32'(rsp_bus.out_chan));
            check_field("out_ctrl", 32'(want.ctrl), 32'(rsp_bus.out_ctrl));
            check_field("out_amount", 32'(want.amount), 32'(unsigned'(rsp_bus.out_amount)));
            check_field("out_payload", want.payload, rsp_bus.out_payload);
            check_field("last", 32'(want.last), 32'(rsp_bus.last));
            results_checked++;
         end
      end
   end

   initial begin : output_receiver
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_output) begin
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(10, 1)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
            repeat ($urandom_range(8, 1)) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("%0t: timeout", $time);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int waited;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.operation   = mcsc_pkg::OP_EVENT;
      req_bus.sample_pos  = '0;
      req_bus.kind        = mcsc_pkg::KIND_NOTE;
      req_bus.chan        = '0;
      req_bus.ctrl_number = '0;
      req_bus.amount      = '0;
      req_bus.payload     = '0;
      csr_we              = 1'b0;
      csr_index           = mcsc_pkg::CSR_WINDOW_START;
      csr_wdata           = '0;
      gaps_on             = 1'b1;
      stalls_on           = 1'b1;
      clear_chase_state();
      win_start = mcsc_pkg::WINDOW_START_RESET;
      win_end   = mcsc_pkg::WINDOW_END_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_pass_through();
      test_chase_into_window();
      test_flush_on_past_event();
      test_flush_on_end_marker();
      test_inverted_window();
      test_window_extremes();
      test_stalled_flush();
      test_random_windows();

      req_bus.valid = 1'b0;
      waited = 0;
      while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_q.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, expected_q.size());
         mismatch_count += expected_q.size();
      end
      $display("Covered %0d input items and %0d results over %0d window settings,",
               items_sent, results_checked, window_settings);
      $display("including a full 16-channel state flush held off by a long output stall.");
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
